// ===== src/wra_pkg.sv =====
// Package for the windowed runtime averager.
// Holds default sizes, the back-end state encoding and the queue status group.
// No dependencies.
package wra_pkg;

  // default window length and depth of the queue between front and back
  localparam int DEF_WINDOW = 8;
  localparam int DEF_QUEUE_DEPTH = 2;

  // fixed field widths
  localparam int SAMPLE_W = 32;
  localparam int MEAN_W = 32;
  localparam int STORED_W = 4;

  // back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_SUB,
    BK_ADD,
    BK_DIV,
    BK_DONE
  } bk_state_t;

  // queue status seen by the back end and the top level
  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== src/wra_front.sv =====
// Front end of the windowed runtime averager: accepts samples, assigns ring slots.
// Classifies each item as append or evict and pushes a command into the queue.
// Depends on wra_pkg.
module wra_front
  import wra_pkg::*;
#(
  parameter int WINDOW = DEF_WINDOW,
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  localparam int CNT_W = $clog2(WINDOW + 1),
  localparam int ENTRY_W = SAMPLE_W + SLOT_W + 1 + CNT_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] sample_ms,
  input  logic                q_full,
  output logic                q_push,
  output logic [ENTRY_W-1:0]  q_entry
);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  fill_count_next;
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] write_slot_next;
  logic              evict;

  // item is taken whenever the queue has room
  assign in_stall = q_full;
  assign q_push = in_valid && !q_full;

  // classify: once the ring is full every item evicts the oldest entry
  assign evict = (fill_count == CNT_FULL);
  assign fill_count_next = evict ? CNT_FULL : fill_count + CNT_W'(1);
  assign write_slot_next = (write_slot == SLOT_LAST) ? '0 : write_slot + SLOT_W'(1);

  // command: sample, slot, evict flag, count after this item
  assign q_entry = {sample_ms, write_slot, evict, fill_count_next};

  // slot and fill tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      write_slot <= '0;
    end else if (q_push) begin
      fill_count <= fill_count_next;
      write_slot <= write_slot_next;
    end
  end

endmodule

// ===== src/wra_queue.sv =====
// Short command queue between the front and back ends of the averager.
// Register-based FIFO of DEPTH entries, first word visible on the read side.
// Depends on wra_pkg.
module wra_queue
  import wra_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = DEF_QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output q_stat_t          stat
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.full = (count == CNT_FULL);
  assign stat.empty = (count == '0);
  assign stat.push = push;
  assign stat.pop = pop;
  assign do_push = push && !stat.full;
  assign do_pop = pop && !stat.empty;
  assign rd_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/wra_back.sv =====
// Back end of the windowed runtime averager: sample ring, running sum, divider.
// Sequencer pops one command, updates ring and sum, divides bit-serially, holds result.
// Depends on wra_pkg.
module wra_back
  import wra_pkg::*;
#(
  parameter int WINDOW = DEF_WINDOW,
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  localparam int CNT_W = $clog2(WINDOW + 1),
  localparam int ENTRY_W = SAMPLE_W + SLOT_W + 1 + CNT_W,
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW)
) (
  input  logic                clk,
  input  logic                rst,
  input  q_stat_t             q_stat,
  input  logic [ENTRY_W-1:0]  q_entry,
  output logic                q_pop,
  output logic                bk_idle,
  output logic                bk_done,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [MEAN_W-1:0]   mean_ms,
  output logic [SAMPLE_W-1:0] latest_ms,
  output logic [STORED_W-1:0] stored_count
);

  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam int PAD_W = (CNT_W > STORED_W) ? CNT_W : STORED_W;

  bk_state_t state;
  bk_state_t state_next;

  logic [SAMPLE_W-1:0] ring [WINDOW];
  logic [SAMPLE_W-1:0] ring_rd;

  logic [SAMPLE_W-1:0] cmd_sample;
  logic [SLOT_W-1:0]   cmd_slot;
  logic                cmd_evict;
  logic [CNT_W-1:0]    cmd_count;

  logic [SUM_W-1:0]    window_sum;
  logic [SUM_W-1:0]    sum_added;
  logic [SUM_W-1:0]    dvd;
  logic [CNT_W-1:0]    rem;
  logic [CNT_W:0]      trial;
  logic                q_bit;
  logic [STEP_W-1:0]   step;
  logic                out_load;
  logic [PAD_W-1:0]    count_pad;

  // sequencer: pop, read ring, subtract, add, divide, hand off
  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    out_load = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          state_next = BK_READ;
        end
      end
      BK_READ: state_next = BK_SUB;
      BK_SUB:  state_next = BK_ADD;
      BK_ADD:  state_next = BK_DIV;
      BK_DIV: begin
        if (step == STEP_W'(1)) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign bk_idle = (state == BK_IDLE);
  assign bk_done = out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (q_pop) begin
      {cmd_sample, cmd_slot, cmd_evict, cmd_count} <= q_entry;
    end
  end

  // sample ring with registered read
  always_ff @(posedge clk) begin
    ring_rd <= ring[cmd_slot];
    if (state == BK_ADD) begin
      ring[cmd_slot] <= cmd_sample;
    end
  end

  // running sum: evicted value out, new sample in
  assign sum_added = window_sum + SUM_W'(cmd_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
    end else if (state == BK_SUB && cmd_evict) begin
      window_sum <= window_sum - SUM_W'(ring_rd);
    end else if (state == BK_ADD) begin
      window_sum <= sum_added;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign trial = {rem, dvd[SUM_W-1]};
  assign q_bit = (trial >= {1'b0, cmd_count});

  always_ff @(posedge clk) begin
    if (state == BK_ADD) begin
      dvd <= sum_added;
      rem <= '0;
      step <= STEP_W'(SUM_W);
    end else if (state == BK_DIV) begin
      dvd <= {dvd[SUM_W-2:0], q_bit};
      rem <= q_bit ? CNT_W'(trial - {1'b0, cmd_count}) : trial[CNT_W-1:0];
      step <= step - STEP_W'(1);
    end
  end

  // output register
  assign count_pad = PAD_W'(cmd_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mean_ms <= dvd[MEAN_W-1:0];
      latest_ms <= cmd_sample;
      stored_count <= count_pad[STORED_W-1:0];
    end
  end

endmodule

// ===== src/windowed_runtime_averager.sv =====
// Top level of the windowed runtime averager (moving mean over the last WINDOW samples).
// Joins front end, command queue and back end.
// Depends on wra_pkg, wra_front, wra_queue, wra_back.
//
//   channel | direction | handshake           | payload
//   input   | in        | in_valid, in_stall   | sample_ms
//   output  | out       | out_valid, out_stall | mean_ms, latest_ms, stored_count
//
// An item passes through the back end's read, subtract, add, divide and done states;
// the divide state runs the bit-serial divider, one quotient bit per cycle over the running sum.
// The front takes items as long as the two-entry queue has room.
// Reset clears counts, pointers, sum and state; the ring needs no clearing pass.
// A stalled result stays in the output register while the back end starts the next item.
module windowed_runtime_averager
  import wra_pkg::*;
#(
  parameter int WINDOW = DEF_WINDOW
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] sample_ms,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [MEAN_W-1:0]   mean_ms,
  output logic [SAMPLE_W-1:0] latest_ms,
  output logic [STORED_W-1:0] stored_count
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int ENTRY_W = SAMPLE_W + SLOT_W + 1 + CNT_W;

  logic               q_push;
  logic               q_pop;
  logic [ENTRY_W-1:0] wr_entry;
  logic [ENTRY_W-1:0] rd_entry;
  q_stat_t            q_stat;
  logic               bk_idle;
  logic               bk_done;

  // slot assignment and classification
  wra_front #(
    .WINDOW(WINDOW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sample_ms(sample_ms),
    .q_full   (q_stat.full),
    .q_push   (q_push),
    .q_entry  (wr_entry)
  );

  // command queue
  wra_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEF_QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_data(wr_entry),
    .pop    (q_pop),
    .rd_data(rd_entry),
    .stat   (q_stat)
  );

  // ring, sum and divider
  wra_back #(
    .WINDOW(WINDOW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .q_entry     (rd_entry),
    .q_pop       (q_pop),
    .bk_idle     (bk_idle),
    .bk_done     (bk_done),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mean_ms     (mean_ms),
    .latest_ms   (latest_ms),
    .stored_count(stored_count)
  );

`ifndef SYNTH
  // the back end only pops a queued command, and only while idle
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    q_stat.pop |-> !q_stat.empty && bk_idle)
    else $error("queue popped while empty or back end busy");

  // an accepted item lands in the queue
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !q_stat.empty)
    else $error("accepted item missing from queue");

  // a new result appears only from a finished division
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid && out_stall)) |-> $past(bk_done))
    else $error("result presented without a finished item");
`endif

endmodule

// ===== bench/average_checker.sv =====
// Checker for the windowed runtime averager: watches both channels, predicts each result
// from the accepted samples and compares it field by field.
// Depends on wra_pkg.
module average_checker
  import wra_pkg::*;
#(
  parameter int WINDOW = DEF_WINDOW
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [SAMPLE_W-1:0] sample_ms,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [MEAN_W-1:0]   mean_ms,
  input  logic [SAMPLE_W-1:0] latest_ms,
  input  logic [STORED_W-1:0] stored_count,
  output int                  err_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // running sum is wide enough for WINDOW full-scale samples
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

  typedef struct packed {
    logic [MEAN_W-1:0]   mean;
    logic [SAMPLE_W-1:0] latest;
    logic [STORED_W-1:0] count;
  } avg_result_t;

  // predicted window state
  logic [SAMPLE_W-1:0] ring [WINDOW];
  int unsigned         held;
  int unsigned         slot;
  logic [SUM_W-1:0]    run_sum;

  avg_result_t expected_averages[$];

  // failure total and results still owed
  int total_fails = 0;
  int queued = 0;

  assign err_count = total_fails;
  assign pending = queued;

  // store one sample, evicting the oldest once full, and work out the new mean
  function automatic avg_result_t store_and_average(logic [SAMPLE_W-1:0] s);
    avg_result_t      r;
    logic [SUM_W-1:0] q;
    if (held == WINDOW) begin
      run_sum = run_sum - SUM_W'(ring[slot]);
    end else begin
      held = held + 1;
    end
    ring[slot] = s;
    run_sum = run_sum + SUM_W'(s);
    slot = (slot == WINDOW - 1) ? 0 : slot + 1;
    q = run_sum / held;
    r.mean = q[MEAN_W-1:0];
    r.latest = s;
    r.count = held[STORED_W-1:0];
    return r;
  endfunction

  // compare accepted results, then queue the prediction for an accepted item
  always @(posedge clk) begin
    avg_result_t want;
    int          fails;
    fails = 0;
    if (rst) begin
      held = 0;
      slot = 0;
      run_sum = '0;
      expected_averages.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_averages.size() == 0) begin
          $error("result with no item pending: mean_ms %0d latest_ms %0d stored_count %0d",
                 mean_ms, latest_ms, stored_count);
          fails++;
        end else begin
          want = expected_averages.pop_front();
          if (mean_ms !== want.mean) begin
            $error("mean_ms: expected %0d, actual %0d", want.mean, mean_ms);
            fails++;
          end
          if (latest_ms !== want.latest) begin
            $error("latest_ms: expected %0d, actual %0d", want.latest, latest_ms);
            fails++;
          end
          if (stored_count !== want.count) begin
            $error("stored_count: expected %0d, actual %0d", want.count, stored_count);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_averages.insert(expected_averages.size(), store_and_average(sample_ms));
      end
    end
    total_fails <= total_fails + fails;
    queued <= expected_averages.size();
  end

endmodule

// ===== bench/tb_windowed_runtime_averager.sv =====
// Testbench top for the windowed runtime averager: clock, reset, sample stimulus and
// output stalls, with the verdict taken from the checker's failure count.
// Depends on wra_pkg, windowed_runtime_averager and average_checker.
module tb_windowed_runtime_averager;
  timeunit 1ns;
  timeprecision 1ps;
  import wra_pkg::*;

  localparam int N_RANDOM  = 1330;
  localparam int LIMIT     = 1_000_000;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE    = 60;

  // window edges: empty start, full-scale fill, wrap to slot zero, bit patterns
  localparam logic [SAMPLE_W-1:0] OPENING [20] = '{
    32'h0000_0000,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'h1234_5678, 32'hFFFF_FFFE
  };

  typedef enum {SMP_ANY, SMP_SMALL, SMP_HIGH, SMP_ONEHOT} sample_kind_t;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] sample_ms = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [MEAN_W-1:0]   mean_ms;
  logic [SAMPLE_W-1:0] latest_ms;
  logic [STORED_W-1:0] stored_count;
  int                  fail_count;
  int                  pending_count;
  int                  hold_requests = 0;
  int                  burst_left = 0;

  always #2 clk = ~clk;

  windowed_runtime_averager #(.WINDOW(DEF_WINDOW)) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_ms   (sample_ms),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mean_ms     (mean_ms),
    .latest_ms   (latest_ms),
    .stored_count(stored_count)
  );

  average_checker #(.WINDOW(DEF_WINDOW)) avg_chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_ms   (sample_ms),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mean_ms     (mean_ms),
    .latest_ms   (latest_ms),
    .stored_count(stored_count),
    .err_count   (fail_count),
    .pending     (pending_count)
  );

  // offer one item, opening a new burst after a random gap when the last one ran out
  task automatic offer_sample(input logic [SAMPLE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    sample_ms <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering until every predicted result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(sample_kind_t kind);
    logic [SAMPLE_W-1:0] v;
    case (kind)
      SMP_SMALL:  v = $urandom_range(0, 1000);
      SMP_HIGH:   v = 32'hFFFF_FFFF - $urandom_range(0, 255);
      SMP_ONEHOT: begin
        v = 32'd1 << $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = ~v;
      end
      default:    v = $urandom;
    endcase
    return v;
  endfunction

  // stimulus and verdict
  initial begin
    sample_kind_t kind;
    int           run_left;
    kind = SMP_ANY;
    run_left = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (OPENING[i]) offer_sample(OPENING[i]);
    drain_results();
    // runs of one sample kind so the window fills with like values
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 150 || n == 800) hold_requests++;
      if (n == 500 || n == 1100) drain_results();
      if (run_left == 0) begin
        kind = sample_kind_t'($urandom_range(0, 3));
        run_left = $urandom_range(1, 20);
      end
      run_left--;
      offer_sample(pick_sample(kind));
    end
    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_windowed_runtime_averager: done, clean");
    end else begin
      $display("tb_windowed_runtime_averager: done, errors");
    end
    $finish;
  end

  // receiver stalls: long hold-off on request, otherwise a randomly chosen pattern
  initial begin
    stall_mode_t mode;
    int          mode_left;
    int          hold_left;
    int          holds_taken;
    int          phase;
    int          period;
    mode = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    holds_taken = 0;
    phase = 0;
    period = 2;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (holds_taken != hold_requests) begin
        holds_taken++;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(64, 600);
          period = $urandom_range(2, 45);
          phase = 0;
        end
        mode_left--;
        phase = (phase + 1) % period;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= (phase < period / 2);
        endcase
      end
    end
  end

  // run limit
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_windowed_runtime_averager: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/wra_pkg.sv
src/wra_front.sv
src/wra_queue.sv
src/wra_back.sv
src/windowed_runtime_averager.sv
bench/average_checker.sv
bench/tb_windowed_runtime_averager.sv
